FILE: src/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg: shared types and constants of the relative compare timer
// Command codes, default counter width and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rct_pkg;

  // Default counter width
  localparam int unsigned CountWidthDef = 32;

  // Width of the delay field and of the reported count
  localparam int unsigned FieldWidth = 32;

  // Command codes carried in the kind field
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_RESET    = 2'd1;
  localparam logic [1:0] KIND_SCHEDULE = 2'd2;
  localparam logic [1:0] KIND_CANCEL   = 2'd3;

  // One result transaction
  typedef struct packed {
    logic                  fire;
    logic [FieldWidth-1:0] count_value;
  } rct_result_t;

endpackage : rct_pkg

`default_nettype wire

FILE: src/relative_compare_timer.sv
// ----------------------------------------------------------------------------
// relative_compare_timer: free-running tick counter with relative compare
// Input register, single-step timer core, result register.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | in_kind, in_delay_ticks
//   out_    | output    | out_valid/out_stall| out_fire, out_count_value
//
// One transaction per cycle sustained while the result is not stalled; each
// result passes the input register, then the result register.
// The timer core updates its state in the cycle a command moves from the
// input register into the result register.
// A stalled result holds the result register and a full input register; in_stall rises only when both are full.
// Synchronous active-low reset clears valids and timer state.
`default_nettype none

module relative_compare_timer
  import rct_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_kind,
  input  wire logic [FieldWidth-1:0] in_delay_ticks,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_fire,
  output logic [FieldWidth-1:0]      out_count_value
);

  logic                  in_valid_r;
  logic [1:0]            kind_r;
  logic [FieldWidth-1:0] delay_r;
  logic                  out_valid_r;
  rct_result_t           result_r;
  rct_result_t           result;
  logic                  advance;
  logic                  in_take;

  // Move a transaction forward when the result slot is free or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r  <= in_kind;
      delay_r <= in_delay_ticks;
    end
  end

  rct_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_valid_r && advance),
    .kind       (kind_r),
    .delay_ticks(delay_r),
    .result     (result)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      result_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fire        = result_r.fire;
  assign out_count_value = result_r.count_value;

endmodule : relative_compare_timer

`default_nettype wire

FILE: src/rct_core.sv
// ----------------------------------------------------------------------------
// rct_core: timer state and single-step update
// Holds counter, compare point, last point and arm flag; applies one
// command per enabled cycle and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module rct_core
  import rct_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire logic [1:0]            kind,
  input  wire logic [FieldWidth-1:0] delay_ticks,
  output rct_result_t                result
);

  logic [COUNT_WIDTH-1:0] tick_count_r,    tick_count_nxt;
  logic [COUNT_WIDTH-1:0] compare_point_r, compare_point_nxt;
  logic [COUNT_WIDTH-1:0] last_point_r,    last_point_nxt;
  logic                   armed_r,         armed_nxt;

  logic [COUNT_WIDTH+FieldWidth-1:0] delay_wide;
  logic [COUNT_WIDTH-1:0]            delay_cw;
  logic [COUNT_WIDTH-1:0]            tick_inc;
  logic [COUNT_WIDTH-1:0]            sched_sum;
  logic [COUNT_WIDTH-1:0]            elapsed;
  logic                              late;
  logic                              fire;
  logic [COUNT_WIDTH+FieldWidth-1:0] count_wide;

  // Fit the delay to the counter width (truncate or zero-extend)
  assign delay_wide = {{COUNT_WIDTH{1'b0}}, delay_ticks};
  assign delay_cw   = delay_wide[COUNT_WIDTH-1:0];

  assign tick_inc  = tick_count_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign sched_sum = last_point_r + delay_cw;
  assign elapsed   = tick_count_r - last_point_r;
  // Late when counter is past the old point by more than the delay, no wrap fix
  assign late      = (tick_count_r > last_point_r) && (delay_cw < elapsed);

  // Next state and fire for the current command
  always_comb begin
    tick_count_nxt    = tick_count_r;
    compare_point_nxt = compare_point_r;
    last_point_nxt    = last_point_r;
    armed_nxt         = armed_r;
    fire              = 1'b0;
    case (kind)
      KIND_TICK: begin
        tick_count_nxt = tick_inc;
        fire           = armed_r && (tick_inc == compare_point_r);
      end
      KIND_RESET: begin
        tick_count_nxt = '0;
        last_point_nxt = '0;
        armed_nxt      = 1'b0;
      end
      KIND_SCHEDULE: begin
        last_point_nxt = sched_sum;
        if (late) begin
          fire = 1'b1;
        end else begin
          compare_point_nxt = sched_sum;
          armed_nxt         = 1'b1;
        end
      end
      KIND_CANCEL: begin
        armed_nxt = 1'b0;
      end
      default: begin
        armed_nxt = armed_r;
      end
    endcase
  end

  // Report the low bits of the count after the step
  assign count_wide         = {{FieldWidth{1'b0}}, tick_count_nxt};
  assign result.fire        = fire;
  assign result.count_value = count_wide[FieldWidth-1:0];

  // Commit state on an enabled step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r    <= '0;
      compare_point_r <= '0;
      last_point_r    <= '0;
      armed_r         <= 1'b0;
    end else if (step_en) begin
      tick_count_r    <= tick_count_nxt;
      compare_point_r <= compare_point_nxt;
      last_point_r    <= last_point_nxt;
      armed_r         <= armed_nxt;
    end
  end

endmodule : rct_core

`default_nettype wire

FILE: src/rct_checker.sv
// ----------------------------------------------------------------------------
// rct_checker: port-level checks of the relative compare timer
// Watches both handshakes and the coupling between them.
// ----------------------------------------------------------------------------
`default_nettype none

module rct_checker
  import rct_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic [1:0]            in_kind,
  input wire logic [FieldWidth-1:0] in_delay_ticks,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  out_fire,
  input wire logic [FieldWidth-1:0] out_count_value
);

  // Result stays offered while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result payload stays put
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_fire) && $stable(out_count_value))
    else $error("stalled result payload changed");

  // Input backpressure only when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

  // No result directly after reset release
  a_reset_empty: assert property (@(posedge clk)
    rst_n && ($past(rst_n) == 1'b0) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule : rct_checker

bind relative_compare_timer rct_checker u_rct_checker (.*);

`default_nettype wire
